// ===== rtl/core/path_string_validator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Path string validator: assertion macros
// Shorthand for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef PATH_STRING_VALIDATOR_CORE_MACROS_SVH
`define PATH_STRING_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PSV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psv check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psv check failed");

`endif

// ===== rtl/core/psv_pkg.sv =====
// ----------------------------------------------------------------------------
// Path string validator package
// Shared types, register codes and character constants.
// ----------------------------------------------------------------------------
package psv_pkg;

   localparam int unsigned PATH_LEN_W = 8;
   localparam int unsigned SEG_LEN_W  = 6;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [PATH_LEN_W-1:0] MAX_PATH_RESET = 8'd128;
   localparam logic [SEG_LEN_W-1:0]  MAX_SEG_RESET  = 6'd48;

   // register index, taken from byte address bit 2
   localparam logic REG_MAX_PATH = 1'b0;
   localparam logic REG_MAX_SEG  = 1'b1;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   typedef struct packed {
      logic [PATH_LEN_W-1:0] max_path_length;
      logic [SEG_LEN_W-1:0]  max_segment_length;
   } cfg_type;

   function automatic logic char_allowed(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
             (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT);
   endfunction

endpackage

// ===== rtl/core/psv_stream_if.sv =====
// ----------------------------------------------------------------------------
// Path string validator channels
// Valid/ready channels for path bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface psv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_end;

   modport source (output valid, output ch, output is_end, input ready);
   modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface psv_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, output valid_res, input ready);
   modport sink   (input valid, input valid_res, output ready);
endinterface

// ===== rtl/core/path_string_validator_core.sv =====
// An end word passes the input register; its verdict goes to the result register.
// Throughput: one word per cycle; path bytes flow even while a verdict waits on rsp,
// an end word waits in the input register only while the result register is held.
// The rate is set by the update of the position/segment counters.
// Reset (synchronous, active high) empties both registers, clears the path state
// and loads the limits with 128 and 48.
// ----------------------------------------------------------------------------
// Path string validator core
// Byte-serial path checker: input register, rule logic, verdict register.
// ----------------------------------------------------------------------------
module path_string_validator_core (
   input  logic                           clock,
   input  logic                           reset,
   psv_req_if.sink                        req_chan,
   psv_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [psv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [psv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   psv_pkg::cfg_type cfg;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_end_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic       out_res_ff, out_res_in;

   // path state
   logic [psv_pkg::PATH_LEN_W-1:0] pos_ff, pos_in;
   logic [psv_pkg::SEG_LEN_W-1:0]  seg_ff, seg_in;
   logic                           fail_ff, fail_in;
   logic                           dot1_ff, dot1_in;
   logic                           dot2_ff, dot2_in;

   logic req_take;
   logic advance;
   logic seg_good;
   logic verdict;

   psv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // A byte word never needs the result register, so it advances at once;
   // an end word advances only when the verdict slot is free or being drained.
   assign advance  = in_valid_ff &&
                     (!in_end_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // current segment: non-empty, within limit, and not "." or ".."
   always_comb begin
      seg_good = (seg_ff != '0) && (seg_ff <= cfg.max_segment_length) &&
                 !(((seg_ff == 6'd1) && dot1_ff) ||
                   ((seg_ff == 6'd2) && dot1_ff && dot2_ff));
   end

   assign verdict = !fail_ff && (pos_ff != '0) && ((pos_ff == 8'd1) || seg_good);

   // rule logic
   always_comb begin
      pos_in  = pos_ff;
      seg_in  = seg_ff;
      fail_in = fail_ff;
      dot1_in = dot1_ff;
      dot2_in = dot2_ff;
      if (advance) begin
         if (in_end_ff) begin
            // verdict taken; clear for the next path
            pos_in  = '0;
            seg_in  = '0;
            fail_in = 1'b0;
            dot1_in = 1'b0;
            dot2_in = 1'b0;
         end else if (!fail_ff) begin
            if (pos_ff >= cfg.max_path_length) begin
               // too long: fail and hold the position
               fail_in = 1'b1;
            end else begin
               if (pos_ff == '0) begin
                  if (in_ch_ff != psv_pkg::CH_SLASH) begin
                     fail_in = 1'b1;
                  end
               end else if (in_ch_ff == psv_pkg::CH_SLASH) begin
                  // close the segment and open a fresh one
                  if (!seg_good) begin
                     fail_in = 1'b1;
                  end
                  seg_in  = '0;
                  dot1_in = 1'b0;
                  dot2_in = 1'b0;
               end else if (!psv_pkg::char_allowed(in_ch_ff)) begin
                  fail_in = 1'b1;
               end else if (seg_ff >= cfg.max_segment_length) begin
                  fail_in = 1'b1;
               end else begin
                  if (seg_ff == 6'd0) begin
                     dot1_in = (in_ch_ff == psv_pkg::CH_DOT);
                  end else if (seg_ff == 6'd1) begin
                     dot2_in = (in_ch_ff == psv_pkg::CH_DOT);
                  end
                  if (seg_ff != '1) begin
                     seg_in = seg_ff + 6'd1;
                  end
               end
               // saturate the position at its top value
               if (pos_ff != '1) begin
                  pos_in = pos_ff + 8'd1;
               end
            end
         end
      end
   end

   // result register: load on an advancing end word, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_end_ff) begin
         out_valid_in = 1'b1;
         out_res_in   = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         seg_ff       <= '0;
         fail_ff      <= 1'b0;
         dot1_ff      <= 1'b0;
         dot2_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         seg_ff       <= seg_in;
         fail_ff      <= fail_in;
         dot1_ff      <= dot1_in;
         dot2_ff      <= dot2_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff  <= req_chan.ch;
         in_end_ff <= req_chan.is_end;
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.valid_res = out_res_ff;

endmodule

// ===== rtl/core/psv_csr.sv =====
// ----------------------------------------------------------------------------
// Path string validator registers
// APB-style register file holding the two length limits.
// ----------------------------------------------------------------------------
module psv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [psv_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [psv_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [psv_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output psv_pkg::cfg_type                    cfg
);

   psv_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            psv_pkg::REG_MAX_PATH: begin
               cfg_in.max_path_length = csr_pwdata[psv_pkg::PATH_LEN_W-1:0];
            end
            psv_pkg::REG_MAX_SEG: begin
               cfg_in.max_segment_length = csr_pwdata[psv_pkg::SEG_LEN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         psv_pkg::REG_MAX_PATH: begin
            csr_prdata = {{(psv_pkg::CSR_DATA_W-psv_pkg::PATH_LEN_W){1'b0}},
                          cfg_ff.max_path_length};
         end
         psv_pkg::REG_MAX_SEG: begin
            csr_prdata = {{(psv_pkg::CSR_DATA_W-psv_pkg::SEG_LEN_W){1'b0}},
                          cfg_ff.max_segment_length};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_path_length    <= psv_pkg::MAX_PATH_RESET;
         cfg_ff.max_segment_length <= psv_pkg::MAX_SEG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/psv_checker.sv =====
// ----------------------------------------------------------------------------
// Path string validator checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "path_string_validator_core_macros.svh"

module psv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_is_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_valid_res
);

   logic end_take;

   assign end_take = req_valid && req_ready && req_is_end;

   // hold a stalled verdict
   `PSV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_valid_res))

   // a fresh verdict follows an end word, via input and result registers
   `PSV_ASSERT_NOW(a_rsp_from_end, clock, reset, $rose(rsp_valid), $past(end_take, 2))

   // reset empties the result register
   `PSV_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

endmodule

bind path_string_validator_core psv_checker u_psv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_is_end    (req_chan.is_end),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_valid_res (rsp_chan.valid_res)
);
